// ===== src/nru_pkg.sv =====
package nru_pkg;

   // table geometry
   localparam int PAGE_COUNT = 4096;
   localparam int OWNER_BITS = 10;
   localparam int ADDR_BITS  = (PAGE_COUNT > 1) ? $clog2(PAGE_COUNT) : 1;

   // fixed widths of the request and response fields
   localparam int PAGE_FIELD_BITS  = 12;
   localparam int OWNER_FIELD_BITS = 10;
   localparam int CLASS_BITS       = 2;

   localparam logic [ADDR_BITS-1:0] LAST_PAGE = ADDR_BITS'(PAGE_COUNT - 1);

   // victim class codes
   localparam logic [CLASS_BITS-1:0] CLASS_NONE  = 2'd0;
   localparam logic [CLASS_BITS-1:0] CLASS_MOD   = 2'd1;
   localparam logic [CLASS_BITS-1:0] CLASS_REF   = 2'd2;
   localparam logic [CLASS_BITS-1:0] CLASS_BOTH  = 2'd3;

   // request mode codes
   localparam logic MODE_ACCESS  = 1'b0;
   localparam logic MODE_COLLECT = 1'b1;

   // one page table entry
   typedef struct packed {
      logic [OWNER_BITS-1:0] owner;
      logic                  ref_bit;
      logic                  mod_bit;
   } entry_type;

   localparam int ENTRY_BITS = $bits(entry_type);

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_ACC,
      ST_SCAN,
      ST_PICK,
      ST_OUT
   } state_type;

   // controller to datapath
   typedef struct packed {
      logic clear_step;
      logic load_req;
      logic acc_eval;
      logic scan_step;
      logic reclaim;
      logic load_out;
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic req_bad;
      logic clear_last;
      logic scan_hit1;
      logic scan_last;
      logic out_free;
   } status_type;

endpackage

// ===== src/nru_ram.sv =====
module nru_ram #(
   parameter int WIDTH = 12,
   parameter int DEPTH = 4096
) (
   input  logic                                      clock,
   input  logic                                      wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                          wr_data,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                          rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // one write port, one registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== src/nru_ctrl.sv =====
module nru_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   input  logic                req_mode,
   output logic                req_stall,
   input  nru_pkg::status_type status,
   output nru_pkg::cmd_type    cmd
);
   import nru_pkg::*;

   state_type state_ff, state_in;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_CLEAR: begin
            if (status.clear_last) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (req_valid) begin
               if (req_mode == MODE_COLLECT) state_in = ST_SCAN;
               else if (status.req_bad)      state_in = ST_OUT;
               else                          state_in = ST_ACC;
            end
         end
         ST_ACC: begin
            state_in = ST_OUT;
         end
         ST_SCAN: begin
            if (status.scan_hit1 || status.scan_last) state_in = ST_PICK;
         end
         ST_PICK: begin
            state_in = ST_OUT;
         end
         ST_OUT: begin
            if (status.out_free) state_in = ST_IDLE;
         end
         default: state_in = ST_CLEAR;
      endcase
   end

   // outputs
   always_comb begin
      cmd       = '0;
      req_stall = 1'b1;
      unique case (state_ff)
         ST_CLEAR: cmd.clear_step = 1'b1;
         ST_IDLE: begin
            req_stall    = 1'b0;
            cmd.load_req = req_valid;
         end
         ST_ACC:   cmd.acc_eval  = 1'b1;
         ST_SCAN:  cmd.scan_step = 1'b1;
         ST_PICK:  cmd.reclaim   = 1'b1;
         ST_OUT:   cmd.load_out  = status.out_free;
         default:  cmd = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   // every reset starts a fresh clearing pass
   a_reset_clears: assert property (@(posedge clock) reset |=> state_ff == ST_CLEAR)
      else $error("controller did not enter clearing pass after reset");

endmodule

// ===== src/nru_datapath.sv =====
module nru_datapath (
   input  logic                                   clock,
   input  logic                                   reset,
   input  nru_pkg::cmd_type                       cmd,
   output nru_pkg::status_type                    status,
   input  logic [nru_pkg::PAGE_FIELD_BITS-1:0]    req_page,
   input  logic [nru_pkg::OWNER_FIELD_BITS-1:0]   req_owner_id,
   input  logic                                   req_is_write,
   output logic                                   rsp_valid,
   input  logic                                   rsp_stall,
   output logic                                   rsp_fault,
   output logic                                   rsp_fault_r,
   output logic                                   rsp_fault_m,
   output logic                                   rsp_victim_found,
   output logic [nru_pkg::PAGE_FIELD_BITS-1:0]    rsp_victim_page,
   output logic [nru_pkg::CLASS_BITS-1:0]         rsp_victim_class,
   output logic                                   rsp_needs_delay
);
   import nru_pkg::*;

   // walk counters
   logic [ADDR_BITS-1:0] clr_idx_ff, clr_idx_in;
   logic [ADDR_BITS-1:0] rd_idx_ff, rd_idx_in;
   logic [ADDR_BITS-1:0] chk_idx_ff, chk_idx_in;
   logic                 chk_valid_ff, chk_valid_in;

   // first candidate of each class
   logic                 hit1_ff, hit1_in;
   logic                 have2_ff, have2_in;
   logic                 have3_ff, have3_in;
   logic [ADDR_BITS-1:0] c1_ff, c1_in;
   logic [ADDR_BITS-1:0] c2_ff, c2_in;
   logic [ADDR_BITS-1:0] c3_ff, c3_in;

   // latched request
   logic [ADDR_BITS-1:0]  page_ff, page_in;
   logic [OWNER_BITS-1:0] owner_ff, owner_in;
   logic                  wr_ff, wr_in;

   // result being built
   logic                       res_fault_ff, res_fault_in;
   logic                       res_r_ff, res_r_in;
   logic                       res_m_ff, res_m_in;
   logic                       res_found_ff, res_found_in;
   logic [PAGE_FIELD_BITS-1:0] res_page_ff, res_page_in;
   logic [CLASS_BITS-1:0]      res_class_ff, res_class_in;
   logic                       res_delay_ff, res_delay_in;

   // output register
   logic                       rsp_valid_ff, rsp_valid_in;
   logic                       rsp_fault_ff, rsp_fault_in;
   logic                       rsp_r_ff, rsp_r_in;
   logic                       rsp_m_ff, rsp_m_in;
   logic                       rsp_found_ff, rsp_found_in;
   logic [PAGE_FIELD_BITS-1:0] rsp_page_ff, rsp_page_in;
   logic [CLASS_BITS-1:0]      rsp_class_ff, rsp_class_in;
   logic                       rsp_delay_ff, rsp_delay_in;

   // table memory
   logic                  ram_wr_en;
   logic [ADDR_BITS-1:0]  ram_wr_addr;
   logic [ENTRY_BITS-1:0] ram_wr_data;
   logic [ADDR_BITS-1:0]  ram_rd_addr;
   logic [ENTRY_BITS-1:0] ram_rd_data;

   entry_type             rd_entry;
   entry_type             new_entry;
   logic [ADDR_BITS-1:0]  req_addr;
   logic [OWNER_BITS-1:0] req_owner;
   logic                  owned;
   logic                  cls1, cls2, cls3;
   logic                  claim;
   logic                  found;
   logic [ADDR_BITS-1:0]  pick;
   logic [CLASS_BITS-1:0] pick_class;

   nru_ram #(
      .WIDTH (ENTRY_BITS),
      .DEPTH (PAGE_COUNT)
   ) u_table (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   // request decode, straight from the input ports
   assign req_addr  = ADDR_BITS'(req_page);
   assign req_owner = OWNER_BITS'(req_owner_id);
   assign ram_rd_addr = cmd.load_req ? req_addr : rd_idx_ff;

   // entry classification on the word just read
   assign rd_entry = entry_type'(ram_rd_data);
   assign owned    = rd_entry.owner != '0;
   assign cls1     = chk_valid_ff && owned && !rd_entry.ref_bit &&  rd_entry.mod_bit;
   assign cls2     = chk_valid_ff && owned &&  rd_entry.ref_bit && !rd_entry.mod_bit;
   assign cls3     = chk_valid_ff && owned &&  rd_entry.ref_bit &&  rd_entry.mod_bit;
   assign claim    = (rd_entry.owner == '0) || (rd_entry.owner == owner_ff);

   // victim choice in class priority order
   always_comb begin
      found      = 1'b1;
      pick       = '0;
      pick_class = CLASS_NONE;
      if (hit1_ff) begin
         pick       = c1_ff;
         pick_class = CLASS_MOD;
      end else if (have2_ff) begin
         pick       = c2_ff;
         pick_class = CLASS_REF;
      end else if (have3_ff) begin
         pick       = c3_ff;
         pick_class = CLASS_BOTH;
      end else begin
         found = 1'b0;
      end
   end

   always_comb begin
      new_entry.owner   = owner_ff;
      new_entry.ref_bit = 1'b1;
      new_entry.mod_bit = rd_entry.mod_bit | wr_ff;
   end

   // status back to the controller
   always_comb begin
      status.req_bad    = (32'(req_page) >= 32'(PAGE_COUNT)) || (req_owner == '0);
      status.clear_last = clr_idx_ff == LAST_PAGE;
      status.scan_hit1  = cls1;
      status.scan_last  = chk_valid_ff && (chk_idx_ff == LAST_PAGE);
      status.out_free   = !rsp_valid_ff || !rsp_stall;
   end

   // next values
   always_comb begin
      clr_idx_in   = clr_idx_ff;
      rd_idx_in    = rd_idx_ff;
      chk_idx_in   = chk_idx_ff;
      chk_valid_in = chk_valid_ff;
      hit1_in      = hit1_ff;
      have2_in     = have2_ff;
      have3_in     = have3_ff;
      c1_in        = c1_ff;
      c2_in        = c2_ff;
      c3_in        = c3_ff;
      page_in      = page_ff;
      owner_in     = owner_ff;
      wr_in        = wr_ff;
      res_fault_in = res_fault_ff;
      res_r_in     = res_r_ff;
      res_m_in     = res_m_ff;
      res_found_in = res_found_ff;
      res_page_in  = res_page_ff;
      res_class_in = res_class_ff;
      res_delay_in = res_delay_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_fault_in = rsp_fault_ff;
      rsp_r_in     = rsp_r_ff;
      rsp_m_in     = rsp_m_ff;
      rsp_found_in = rsp_found_ff;
      rsp_page_in  = rsp_page_ff;
      rsp_class_in = rsp_class_ff;
      rsp_delay_in = rsp_delay_ff;
      ram_wr_en    = 1'b0;
      ram_wr_addr  = '0;
      ram_wr_data  = '0;

      // clearing pass after reset, one entry a cycle
      if (cmd.clear_step) begin
         ram_wr_en   = 1'b1;
         ram_wr_addr = clr_idx_ff;
         clr_idx_in  = clr_idx_ff + 1'b1;
      end

      // take the request word and start from an all-zero result
      if (cmd.load_req) begin
         page_in      = req_addr;
         owner_in     = req_owner;
         wr_in        = req_is_write;
         res_fault_in = 1'b0;
         res_r_in     = 1'b0;
         res_m_in     = 1'b0;
         res_found_in = 1'b0;
         res_page_in  = '0;
         res_class_in = CLASS_NONE;
         res_delay_in = 1'b0;
         rd_idx_in    = '0;
         chk_valid_in = 1'b0;
         hit1_in      = 1'b0;
         have2_in     = 1'b0;
         have3_in     = 1'b0;
      end

      // access: claim the page or report the fault
      if (cmd.acc_eval) begin
         if (claim) begin
            ram_wr_en   = 1'b1;
            ram_wr_addr = page_ff;
            ram_wr_data = new_entry;
         end else begin
            res_fault_in = 1'b1;
            res_r_in     = rd_entry.ref_bit;
            res_m_in     = rd_entry.mod_bit;
         end
      end

      // scan: issue the next read, check the previous one
      if (cmd.scan_step) begin
         rd_idx_in    = rd_idx_ff + 1'b1;
         chk_valid_in = 1'b1;
         chk_idx_in   = rd_idx_ff;
         if (cls1 && !hit1_ff) begin
            hit1_in = 1'b1;
            c1_in   = chk_idx_ff;
         end
         if (cls2 && !have2_ff) begin
            have2_in = 1'b1;
            c2_in    = chk_idx_ff;
         end
         if (cls3 && !have3_ff) begin
            have3_in = 1'b1;
            c3_in    = chk_idx_ff;
         end
      end

      // free the chosen victim
      if (cmd.reclaim && found) begin
         ram_wr_en    = 1'b1;
         ram_wr_addr  = pick;
         res_found_in = 1'b1;
         res_page_in  = PAGE_FIELD_BITS'(pick);
         res_class_in = pick_class;
         res_delay_in = pick_class != CLASS_REF;
      end

      // output register
      if (cmd.load_out) begin
         rsp_valid_in = 1'b1;
         rsp_fault_in = res_fault_ff;
         rsp_r_in     = res_r_ff;
         rsp_m_in     = res_m_ff;
         rsp_found_in = res_found_ff;
         rsp_page_in  = res_page_ff;
         rsp_class_in = res_class_ff;
         rsp_delay_in = res_delay_ff;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         clr_idx_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         clr_idx_ff   <= clr_idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      rd_idx_ff    <= rd_idx_in;
      chk_idx_ff   <= chk_idx_in;
      chk_valid_ff <= chk_valid_in;
      hit1_ff      <= hit1_in;
      have2_ff     <= have2_in;
      have3_ff     <= have3_in;
      c1_ff        <= c1_in;
      c2_ff        <= c2_in;
      c3_ff        <= c3_in;
      page_ff      <= page_in;
      owner_ff     <= owner_in;
      wr_ff        <= wr_in;
      res_fault_ff <= res_fault_in;
      res_r_ff     <= res_r_in;
      res_m_ff     <= res_m_in;
      res_found_ff <= res_found_in;
      res_page_ff  <= res_page_in;
      res_class_ff <= res_class_in;
      res_delay_ff <= res_delay_in;
      rsp_fault_ff <= rsp_fault_in;
      rsp_r_ff     <= rsp_r_in;
      rsp_m_ff     <= rsp_m_in;
      rsp_found_ff <= rsp_found_in;
      rsp_page_ff  <= rsp_page_in;
      rsp_class_ff <= rsp_class_in;
      rsp_delay_ff <= rsp_delay_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_fault        = rsp_fault_ff;
   assign rsp_fault_r      = rsp_r_ff;
   assign rsp_fault_m      = rsp_m_ff;
   assign rsp_victim_found = rsp_found_ff;
   assign rsp_victim_page  = rsp_page_ff;
   assign rsp_victim_class = rsp_class_ff;
   assign rsp_needs_delay  = rsp_delay_ff;

   // a new word never overwrites one still held by the consumer
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.load_out |-> (!rsp_valid_ff || !rsp_stall))
      else $error("response word overwritten while stalled");

   // victim flag and class always agree after a reclaim
   a_class_consistent: assert property (@(posedge clock) disable iff (reset)
      cmd.reclaim |=> (res_found_ff == (res_class_ff != CLASS_NONE)))
      else $error("victim flag and class disagree");

   // a word never carries both a fault and a victim
   a_fault_xor_victim: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> !(rsp_fault_ff && rsp_found_ff))
      else $error("response carries both fault and victim");

endmodule

// ===== src/nru_page_table_policy.sv =====
// an access reads its entry, then claims it or reports a fault, then loads its response word
//   (a page out of range or a zero owner goes straight to the response); a collect scans,
//   frees the victim it picks, if any, then loads its word; one word at a time, a new request
//   taken only after the last response word is loaded; a collect walks the single table read
//   port one entry per cycle, ending early when a class-1 page turns up; a waiting response adds stalls
// reset: synchronous, clears control state then clears all PAGE_COUNT entries, req_stall high
module nru_page_table_policy (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic                                 req_mode,
   input  logic [nru_pkg::PAGE_FIELD_BITS-1:0]  req_page,
   input  logic [nru_pkg::OWNER_FIELD_BITS-1:0] req_owner_id,
   input  logic                                 req_is_write,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic                                 rsp_fault,
   output logic                                 rsp_fault_r,
   output logic                                 rsp_fault_m,
   output logic                                 rsp_victim_found,
   output logic [nru_pkg::PAGE_FIELD_BITS-1:0]  rsp_victim_page,
   output logic [nru_pkg::CLASS_BITS-1:0]       rsp_victim_class,
   output logic                                 rsp_needs_delay
);
   import nru_pkg::*;

   cmd_type    cmd;
   status_type status;

   // sequencer
   nru_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_mode  (req_mode),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   // table, scan logic and response register
   nru_datapath u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .status           (status),
      .req_page         (req_page),
      .req_owner_id     (req_owner_id),
      .req_is_write     (req_is_write),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_fault        (rsp_fault),
      .rsp_fault_r      (rsp_fault_r),
      .rsp_fault_m      (rsp_fault_m),
      .rsp_victim_found (rsp_victim_found),
      .rsp_victim_page  (rsp_victim_page),
      .rsp_victim_class (rsp_victim_class),
      .rsp_needs_delay  (rsp_needs_delay)
   );

endmodule

// ===== sim/tb_nru_page_table_policy.sv =====
`timescale 1ns / 100ps

module tb_nru_page_table_policy;
   import nru_pkg::*;

   localparam int WATCHDOG_LIMIT = 25000;
   localparam int HOLD_CYCLES    = 300;
   localparam int SETTLE_CYCLES  = 10;

   // one response word as the block presents it
   typedef struct packed {
      logic                       fault;
      logic                       fault_r;
      logic                       fault_m;
      logic                       victim_found;
      logic [PAGE_FIELD_BITS-1:0] victim_page;
      logic [CLASS_BITS-1:0]      victim_class;
      logic                       needs_delay;
   } answer_type;

   // shadow page table, predicts each response word and checks the block against it
   class page_table_mirror;
      logic [OWNER_BITS-1:0] owner_of [PAGE_COUNT];
      bit                    referenced [PAGE_COUNT];
      bit                    modified [PAGE_COUNT];
      answer_type            answers_due [$];
      int                    mismatches;
      int                    accesses;
      int                    faults;
      int                    zero_owner;
      int                    scans;
      int                    reclaims [4];

      function new();
         foreach (owner_of[i]) begin
            owner_of[i]   = '0;
            referenced[i] = 1'b0;
            modified[i]   = 1'b0;
         end
         mismatches = 0;
         accesses   = 0;
         faults     = 0;
         zero_owner = 0;
         scans      = 0;
         foreach (reclaims[i]) reclaims[i] = 0;
      endfunction

      // claim a free or own page, refuse a page held by someone else; a bad page or zero owner gives an empty word
      function answer_type mirror_access(logic [PAGE_FIELD_BITS-1:0] page,
                                         logic [OWNER_FIELD_BITS-1:0] owner, logic wr);
         answer_type            ans = '0;
         logic [OWNER_BITS-1:0] id;
         id = owner[OWNER_BITS-1:0];
         accesses++;
         if (int'(page) >= PAGE_COUNT || id == '0) begin
            zero_owner++;
            return ans;
         end
         if (owner_of[page] == '0 || owner_of[page] == id) begin
            owner_of[page]   = id;
            referenced[page] = 1'b1;
            if (wr) modified[page] = 1'b1;
         end else begin
            ans.fault   = 1'b1;
            ans.fault_r = referenced[page];
            ans.fault_m = modified[page];
            faults++;
         end
         return ans;
      endfunction

      // first class-1 page wins at once, else first class-2, else first class-3
      function answer_type mirror_collect();
         answer_type            ans = '0;
         int                    i;
         int                    pick;
         int                    first_ref;
         int                    first_both;
         logic [CLASS_BITS-1:0] cls;
         pick       = -1;
         first_ref  = -1;
         first_both = -1;
         cls        = CLASS_NONE;
         scans++;
         for (i = 0; i < PAGE_COUNT; i++) begin
            if (owner_of[i] == '0) continue;
            if (!referenced[i] && modified[i]) begin
               pick = i;
               cls  = CLASS_MOD;
               break;
            end
            if (referenced[i] && !modified[i] && first_ref < 0) first_ref = i;
            else if (referenced[i] && modified[i] && first_both < 0) first_both = i;
         end
         if (cls == CLASS_NONE) begin
            if (first_ref >= 0) begin
               pick = first_ref;
               cls  = CLASS_REF;
            end else if (first_both >= 0) begin
               pick = first_both;
               cls  = CLASS_BOTH;
            end else begin
               reclaims[CLASS_NONE]++;
               return ans;
            end
         end
         ans.victim_found = 1'b1;
         ans.victim_page  = PAGE_FIELD_BITS'(pick);
         ans.victim_class = cls;
         ans.needs_delay  = (cls != CLASS_REF);
         owner_of[pick]   = '0;
         referenced[pick] = 1'b0;
         modified[pick]   = 1'b0;
         reclaims[cls]++;
         return ans;
      endfunction

      function void note_request(logic mode, logic [PAGE_FIELD_BITS-1:0] page,
                                 logic [OWNER_FIELD_BITS-1:0] owner, logic wr);
         if (mode == MODE_COLLECT) answers_due.push_back(mirror_collect());
         else answers_due.push_back(mirror_access(page, owner, wr));
      endfunction

      function void compare_field(string what, logic [15:0] want, logic [15:0] seen);
         if (want !== seen) begin
            $display("%0t: %s expected %0h, got %0h", $time, what, want, seen);
            mismatches++;
         end
      endfunction

      function void check_response(answer_type got);
         answer_type want;
         if (answers_due.size() == 0) begin
            $display("%0t: unexpected response word %0h", $time, got);
            mismatches++;
            return;
         end
         want = answers_due.pop_front();
         compare_field("fault", 16'(want.fault), 16'(got.fault));
         compare_field("fault_r", 16'(want.fault_r), 16'(got.fault_r));
         compare_field("fault_m", 16'(want.fault_m), 16'(got.fault_m));
         compare_field("victim_found", 16'(want.victim_found), 16'(got.victim_found));
         compare_field("victim_page", 16'(want.victim_page), 16'(got.victim_page));
         compare_field("victim_class", 16'(want.victim_class), 16'(got.victim_class));
         compare_field("needs_delay", 16'(want.needs_delay), 16'(got.needs_delay));
      endfunction

      function int pending();
         return answers_due.size();
      endfunction
   endclass

   logic                        clock = 1'b0;
   logic                        reset = 1'b1;
   logic                        req_valid = 1'b0;
   logic                        req_stall;
   logic                        req_mode = MODE_ACCESS;
   logic [PAGE_FIELD_BITS-1:0]  req_page = '0;
   logic [OWNER_FIELD_BITS-1:0] req_owner_id = '0;
   logic                        req_is_write = 1'b0;
   logic                        rsp_valid;
   logic                        rsp_stall = 1'b0;
   logic                        rsp_fault;
   logic                        rsp_fault_r;
   logic                        rsp_fault_m;
   logic                        rsp_victim_found;
   logic [PAGE_FIELD_BITS-1:0]  rsp_victim_page;
   logic [CLASS_BITS-1:0]       rsp_victim_class;
   logic                        rsp_needs_delay;

   page_table_mirror            book;
   bit                          quiet = 1'b0;
   int                          holds_asked = 0;
   int                          holds_done = 0;
   int                          stuck_cycles = 0;
   logic [PAGE_FIELD_BITS-1:0]  hot_pages [8];
   logic [OWNER_FIELD_BITS-1:0] hot_owners [4];

   nru_page_table_policy uut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_mode         (req_mode),
      .req_page         (req_page),
      .req_owner_id     (req_owner_id),
      .req_is_write     (req_is_write),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_fault        (rsp_fault),
      .rsp_fault_r      (rsp_fault_r),
      .rsp_fault_m      (rsp_fault_m),
      .rsp_victim_found (rsp_victim_found),
      .rsp_victim_page  (rsp_victim_page),
      .rsp_victim_class (rsp_victim_class),
      .rsp_needs_delay  (rsp_needs_delay)
   );

   initial begin
      forever #10 clock = ~clock;
   end

   // receiver: random stalls, plus long hold-offs on request
   initial begin : receiver
      int stretch_left;
      stretch_left = 0;
      forever begin
         @(posedge clock);
         if (stretch_left == 0 && holds_done != holds_asked) begin
            holds_done++;
            stretch_left = HOLD_CYCLES;
         end
         if (stretch_left != 0) begin
            stretch_left--;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= !quiet && ($urandom_range(0, 99) < 7);
         end
      end
   end

   // both handshakes seen at the edge, plus the stuck-run watchdog
   always @(posedge clock) begin
      answer_type got;
      bit         moved;
      moved = 1'b0;
      if (!reset) begin
         if (rsp_valid === 1'b1 && rsp_stall === 1'b0) begin
            got = '{rsp_fault, rsp_fault_r, rsp_fault_m, rsp_victim_found,
                    rsp_victim_page, rsp_victim_class, rsp_needs_delay};
            book.check_response(got);
            moved = 1'b1;
         end
         if (req_valid && req_stall === 1'b0) begin
            book.note_request(req_mode, req_page, req_owner_id, req_is_write);
            moved = 1'b1;
         end
      end
      stuck_cycles = moved ? 0 : stuck_cycles + 1;
      if (stuck_cycles >= WATCHDOG_LIMIT) begin
         $display("%0t: no word moved for %0d cycles", $time, stuck_cycles);
         $display("tb_nru_page_table_policy failed");
         $finish;
      end
   end

   // offer one request word, with an occasional idle gap in front
   task automatic send_word(input logic mode, input logic [PAGE_FIELD_BITS-1:0] page,
                            input logic [OWNER_FIELD_BITS-1:0] owner, input logic wr);
      while (!quiet && $urandom_range(0, 99) < 7) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid    <= 1'b1;
      req_mode     <= mode;
      req_page     <= page;
      req_owner_id <= owner;
      req_is_write <= wr;
      @(posedge clock);
      while (req_stall !== 1'b0) @(posedge clock);
   endtask

   task automatic send_collect();
      send_word(MODE_COLLECT, PAGE_FIELD_BITS'($urandom), OWNER_FIELD_BITS'($urandom),
                1'($urandom));
   endtask

   // mostly a small set of pages and owners so that claims, faults and reclaims meet
   task automatic random_word();
      int                          pick;
      logic [PAGE_FIELD_BITS-1:0]  page;
      logic [OWNER_FIELD_BITS-1:0] owner;
      pick  = $urandom_range(0, 99);
      page  = ($urandom_range(0, 9) == 0) ? PAGE_FIELD_BITS'($urandom)
                                          : hot_pages[$urandom_range(0, 7)];
      owner = ($urandom_range(0, 5) == 0) ? OWNER_FIELD_BITS'($urandom_range(1, 1023))
                                          : hot_owners[$urandom_range(0, 3)];
      if (pick < 22) send_collect();
      else if (pick < 25) send_word(MODE_ACCESS, page, '0, 1'($urandom));
      else send_word(MODE_ACCESS, page, owner, 1'($urandom));
   endtask

   // stop offering until every response word has come back
   task automatic wait_for_answers();
      req_valid <= 1'b0;
      @(posedge clock);
      while (book.pending() != 0) @(posedge clock);
   endtask

   initial begin
      book = new();
      hot_pages  = '{12'd0, 12'hFFF, 12'd1, 12'd2, 12'h800,
                     PAGE_FIELD_BITS'($urandom), PAGE_FIELD_BITS'($urandom),
                     PAGE_FIELD_BITS'($urandom)};
      hot_owners = '{10'd1, 10'h3FF, 10'd2, OWNER_FIELD_BITS'($urandom_range(3, 1022))};
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // directed: empty scan, claims, faults, zero owner, reclaim of each reachable class
      send_collect();
      send_word(MODE_ACCESS, 12'd0, 10'd1, 1'b0);
      send_word(MODE_ACCESS, 12'hFFF, 10'h3FF, 1'b1);
      send_word(MODE_ACCESS, 12'd0, 10'd2, 1'b0);
      send_word(MODE_ACCESS, 12'hFFF, 10'd5, 1'b1);
      send_word(MODE_ACCESS, 12'd7, 10'd0, 1'b1);
      send_word(MODE_ACCESS, 12'd0, 10'd1, 1'b1);
      send_word(MODE_ACCESS, 12'd100, 10'd3, 1'b0);
      send_word(MODE_ACCESS, 12'd100, 10'd3, 1'b0);
      send_collect();
      send_collect();
      send_collect();
      send_collect();
      send_word(MODE_ACCESS, 12'd0, 10'd2, 1'b0);
      send_word(MODE_ACCESS, 12'hAAA, 10'h155, 1'b1);
      send_word(MODE_ACCESS, 12'h555, 10'h2AA, 1'b0);
      send_word(MODE_ACCESS, 12'h555, 10'h155, 1'b1);
      send_collect();
      wait_for_answers();

      // random with idling on both sides
      repeat (40) random_word();

      // long stretch with no idling at all
      quiet = 1'b1;
      repeat (30) random_word();
      quiet = 1'b0;

      // receiver holds off while requests keep coming, so the block backs up
      holds_asked++;
      repeat (24) random_word();
      wait_for_answers();

      repeat (30) random_word();

      // drain and let any stray word show up
      wait_for_answers();
      repeat (SETTLE_CYCLES) @(posedge clock);

      $display("covered %0d accesses: %0d faults, %0d with a zero owner",
               book.accesses, book.faults, book.zero_owner);
      $display("covered %0d scans: %0d class-2 and %0d class-3 reclaims, %0d empty",
               book.scans, book.reclaims[CLASS_REF], book.reclaims[CLASS_BOTH],
               book.reclaims[CLASS_NONE]);
      if (book.mismatches == 0 && book.pending() == 0) begin
         $display("tb_nru_page_table_policy passed");
      end else begin
         $display("tb_nru_page_table_policy failed");
      end
      $finish;
   end

endmodule
